### rtl/frdc_pkg.sv
package frdc_pkg;

  // operation codes carried by an input item
  typedef enum logic [1:0] {
    OpAdvance     = 2'd0,
    OpApplyPacked = 2'd1,
    OpTurnOn      = 2'd2,
    OpTurnOff     = 2'd3
  } op_e;

  // packed setting layout
  localparam int unsigned PackOnBit    = 7;
  localparam int unsigned PackSpeedBit = 6;
  localparam int unsigned PackIdxW     = 6;
  localparam int unsigned TableSize    = 16;
  localparam int unsigned TableIdxW    = 4;
  localparam int unsigned StepW        = 4;

  // fixed ratio table, numerator and denominator per index
  localparam logic [3:0] RatioNumTab [TableSize] =
    '{4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2,
      4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd6};
  localparam logic [3:0] RatioDenTab [TableSize] =
    '{4'd0, 4'd2, 4'd3, 4'd4, 4'd6, 4'd12, 4'd3, 4'd4,
      4'd6, 4'd12, 4'd4, 4'd6, 4'd12, 4'd6, 4'd12, 4'd12};

  // one input item
  typedef struct packed {
    logic [1:0] operation;
    logic       want_high_speed;
    logic [7:0] on_steps;
    logic [7:0] cycle_steps;
    logic [7:0] packed_setting;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic       relay_drive;
    logic       speed_line_high;
    logic       commanded_on;
    logic [7:0] packed_status;
    logic [3:0] step_in_cycle;
    logic       cycle_done;
  } res_t;

  // first table index holding the given ratio, 0 when not found
  function automatic logic [TableIdxW-1:0] ratio_index(logic [7:0] num, logic [7:0] den);
    logic [TableIdxW-1:0] idx;
    idx = '0;
    for (int i = TableSize - 1; i >= 0; i--) begin
      if (8'(RatioNumTab[i]) == num && 8'(RatioDenTab[i]) == den) begin
        idx = TableIdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/frdc_cmd_if.sv
interface frdc_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       want_high_speed;
  logic [7:0] on_steps;
  logic [7:0] cycle_steps;
  logic [7:0] packed_setting;

  modport source (
    output valid, operation, want_high_speed, on_steps, cycle_steps, packed_setting,
    input  ready
  );
  modport sink (
    input  valid, operation, want_high_speed, on_steps, cycle_steps, packed_setting,
    output ready
  );
endinterface

### rtl/frdc_res_if.sv
interface frdc_res_if;
  logic       valid;
  logic       ready;
  logic       relay_drive;
  logic       speed_line_high;
  logic       commanded_on;
  logic [7:0] packed_status;
  logic [3:0] step_in_cycle;
  logic       cycle_done;

  modport source (
    output valid, relay_drive, speed_line_high, commanded_on, packed_status,
           step_in_cycle, cycle_done,
    input  ready
  );
  modport sink (
    input  valid, relay_drive, speed_line_high, commanded_on, packed_status,
           step_in_cycle, cycle_done,
    output ready
  );
endinterface

### rtl/frdc_cfg_if.sv
interface frdc_cfg_if;
  logic valid;
  logic ready;
  logic fan_enabled;

  modport source (
    output valid, fan_enabled,
    input  ready
  );
  modport sink (
    input  valid, fan_enabled,
    output ready
  );
endinterface

### rtl/frdc_state.sv
module frdc_state #(
  parameter int unsigned RATIO_LIMIT = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             fan_enabled_i,
  input  frdc_pkg::cmd_t   cmd_i,
  output frdc_pkg::res_t   res_o
);

  localparam int unsigned RatioW = $clog2(RATIO_LIMIT + 1);

  logic              on_q, on_d;
  logic              spd_q, spd_d;
  logic [RatioW-1:0] num_q, num_d;
  logic [RatioW-1:0] den_q, den_d;
  logic [RatioW-1:0] cnt_q, cnt_d;
  frdc_pkg::res_t    res_q, res_d;

  logic              want_on;
  logic              want_off;
  logic              req_spd;
  logic [7:0]        req_num;
  logic [7:0]        req_den;
  logic              same_setting;
  logic              bad_ratio;
  logic [RatioW:0]   phase;
  logic              relay;
  logic [frdc_pkg::TableIdxW-1:0] tab_idx;
  logic [frdc_pkg::TableIdxW-1:0] stat_idx;

  // decode the operation into a turn-on request, a turn-off request or neither, with the requested speed and ratio
  always_comb begin
    want_on  = 1'b0;
    want_off = 1'b0;
    req_spd  = cmd_i.want_high_speed;
    req_num  = cmd_i.on_steps;
    req_den  = cmd_i.cycle_steps;
    tab_idx  = cmd_i.packed_setting[frdc_pkg::TableIdxW-1:0];
    unique case (frdc_pkg::op_e'(cmd_i.operation))
      frdc_pkg::OpAdvance: begin
        want_on = 1'b0;
      end
      frdc_pkg::OpApplyPacked: begin
        if (cmd_i.packed_setting[frdc_pkg::PackOnBit]) begin
          want_on = 1'b1;
          req_spd = cmd_i.packed_setting[frdc_pkg::PackSpeedBit];
          if (cmd_i.packed_setting[frdc_pkg::PackIdxW-1:0] <
              frdc_pkg::PackIdxW'(frdc_pkg::TableSize)) begin
            req_num = 8'(frdc_pkg::RatioNumTab[tab_idx]);
            req_den = 8'(frdc_pkg::RatioDenTab[tab_idx]);
          end else begin
            req_num = '0;
            req_den = '0;
          end
        end else begin
          want_off = 1'b1;
        end
      end
      frdc_pkg::OpTurnOn: begin
        want_on = 1'b1;
      end
      frdc_pkg::OpTurnOff: begin
        want_off = 1'b1;
      end
    endcase
  end

  assign same_setting = on_q && (spd_q == req_spd) &&
                        (req_num == 8'(num_q)) && (req_den == 8'(den_q));
  assign bad_ratio    = (req_num > 8'(RATIO_LIMIT)) || (req_den > 8'(RATIO_LIMIT)) ||
                        (req_num > req_den);

  // next state after this item
  always_comb begin
    on_d  = on_q;
    spd_d = spd_q;
    num_d = num_q;
    den_d = den_q;
    cnt_d = cnt_q;
    if (frdc_pkg::op_e'(cmd_i.operation) == frdc_pkg::OpAdvance) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
      end else if (den_q != '0) begin
        cnt_d = den_q - 1'b1;
      end
    end
    if (want_on && fan_enabled_i && !same_setting) begin
      on_d  = 1'b1;
      spd_d = req_spd;
      if (bad_ratio) begin
        num_d = '0;
        den_d = '0;
        cnt_d = '0;
      end else begin
        num_d = RatioW'(req_num);
        den_d = RatioW'(req_den);
        cnt_d = (req_den != '0) ? RatioW'(req_den - 8'd1) : '0;
      end
    end
    if (want_off) begin
      cnt_d = '0;
      if (fan_enabled_i) begin
        on_d = 1'b0;
      end
    end
  end

  // result from the updated state
  assign phase    = {1'b0, den_d} - {1'b0, cnt_d};
  assign stat_idx = frdc_pkg::ratio_index(8'(num_d), 8'(den_d));

  always_comb begin
    relay = on_d;
    if (on_d && num_d != '0 && den_d != '0) begin
      relay = phase[RatioW] || (phase[RatioW-1:0] <= num_d);
    end
    res_d.relay_drive     = relay;
    res_d.speed_line_high = relay & spd_d;
    res_d.commanded_on    = on_d;
    res_d.packed_status   = on_d ? {1'b1, spd_d, frdc_pkg::PackIdxW'(stat_idx)} : 8'd0;
    res_d.step_in_cycle   = phase[frdc_pkg::StepW-1:0];
    res_d.cycle_done      = (cnt_d == '0);
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q  <= 1'b0;
      spd_q <= 1'b0;
      num_q <= '0;
      den_q <= '0;
      cnt_q <= '0;
    end else if (step_i) begin
      on_q  <= on_d;
      spd_q <= spd_d;
      num_q <= num_d;
      den_q <= den_d;
      cnt_q <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### rtl/fan_ratio_duty_cycler_core.sv
// Fan relay duty-cycler.
// Channels: cmd_i takes one command item per handshake (operation, speed,
// explicit ratio, packed setting); res_o returns exactly one result item per
// command (relay drive, speed line, on flag, packed status, cycle position,
// cycle done); cfg_i writes the fan_enabled register and is always ready.
// The user must write configuration only while no command is in flight;
// the block does not enforce this. An accepted command waits in the input
// register, then moves into the result register once that is free or taken.
// Throughput: one item per cycle while res_o is taken; the state update and
// result logic sit in one short combinational stage between the two registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; cmd_i.ready drops only when both are
// full. It rises again in the same cycle that res_o is taken.
// Reset: the fan is off, speed low, ratio 0/0, counter 0, fan_enabled 1,
// and both registers are empty.
module fan_ratio_duty_cycler_core #(
  parameter int unsigned RATIO_LIMIT = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  frdc_cmd_if.sink   cmd_i,
  frdc_res_if.source res_o,
  frdc_cfg_if.sink   cfg_i
);

  logic             in_vld_q;
  frdc_pkg::cmd_t   cmd_q;
  logic             out_vld_q;
  logic             enabled_q;
  logic             step;
  frdc_pkg::res_t   res;

  // move an item from the input register into the result register
  assign step        = in_vld_q && (!out_vld_q || res_o.ready);
  assign cmd_i.ready = !in_vld_q || step;
  assign cfg_i.ready = 1'b1;

  // valid flags and the fan_enabled register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      enabled_q <= 1'b1;
    end else begin
      if (cmd_i.valid && cmd_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        enabled_q <= cfg_i.fan_enabled;
      end
    end
  end

  // command payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      cmd_q.operation       <= cmd_i.operation;
      cmd_q.want_high_speed <= cmd_i.want_high_speed;
      cmd_q.on_steps        <= cmd_i.on_steps;
      cmd_q.cycle_steps     <= cmd_i.cycle_steps;
      cmd_q.packed_setting  <= cmd_i.packed_setting;
    end
  end

  frdc_state #(
    .RATIO_LIMIT (RATIO_LIMIT)
  ) u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .fan_enabled_i (enabled_q),
    .cmd_i         (cmd_q),
    .res_o         (res)
  );

  // result channel
  assign res_o.valid           = out_vld_q;
  assign res_o.relay_drive     = res.relay_drive;
  assign res_o.speed_line_high = res.speed_line_high;
  assign res_o.commanded_on    = res.commanded_on;
  assign res_o.packed_status   = res.packed_status;
  assign res_o.step_in_cycle   = res.step_in_cycle;
  assign res_o.cycle_done      = res.cycle_done;

endmodule
